>>> rtl/core/hef_pkg.sv
// ----------------------------------------------------------------------------
// hef_pkg
// Shared types, register-file map and micro-program of the HLL face flux core.
// ----------------------------------------------------------------------------
package hef_pkg;

  // Default word format and the fixed field widths of the ports.
  localparam int WORD_BITS_DEF = 48;
  localparam int FRAC_BITS_DEF = 24;
  localparam int UW = 47;
  localparam int SW = 48;
  localparam int NW = 26;
  localparam int OW = 48;

  localparam int ADDR_W = 6;
  localparam int SEG_W  = 4;
  localparam int STEP_W = 5;

  // Register-file map.
  localparam logic [ADDR_W-1:0] A_O0   = 6'd0;
  localparam logic [ADDR_W-1:0] A_N0   = 6'd7;
  localparam logic [ADDR_W-1:0] A_NX   = 6'd14;
  localparam logic [ADDR_W-1:0] A_NY   = 6'd15;
  localparam logic [ADDR_W-1:0] A_NZ   = 6'd16;
  localparam logic [ADDR_W-1:0] A_AREA = 6'd17;
  localparam logic [ADDR_W-1:0] A_ONE  = 6'd18;
  localparam logic [ADDR_W-1:0] A_UN_O = 6'd19;
  localparam logic [ADDR_W-1:0] A_UN_N = 6'd20;
  localparam logic [ADDR_W-1:0] A_E    = 6'd21;
  localparam logic [ADDR_W-1:0] A_T    = 6'd22;
  localparam logic [ADDR_W-1:0] A_MO   = 6'd23;
  localparam logic [ADDR_W-1:0] A_MN   = 6'd24;
  localparam logic [ADDR_W-1:0] A_FO1  = 6'd25;
  localparam logic [ADDR_W-1:0] A_FN1  = 6'd29;
  localparam logic [ADDR_W-1:0] A_QO1  = 6'd33;
  localparam logic [ADDR_W-1:0] A_QN1  = 6'd37;
  localparam logic [ADDR_W-1:0] A_T1   = 6'd41;
  localparam logic [ADDR_W-1:0] A_T2   = 6'd42;
  localparam logic [ADDR_W-1:0] A_SL   = 6'd43;
  localparam logic [ADDR_W-1:0] A_SR   = 6'd44;
  localparam logic [ADDR_W-1:0] A_R    = 6'd45;
  localparam logic [ADDR_W-1:0] A_SLSR = 6'd46;
  localparam logic [ADDR_W-1:0] A_X    = 6'd47;
  localparam logic [ADDR_W-1:0] A_Y    = 6'd48;

  // Program segments.
  localparam logic [SEG_W-1:0] SEG_OWN    = 4'd0;
  localparam logic [SEG_W-1:0] SEG_NBR    = 4'd1;
  localparam logic [SEG_W-1:0] SEG_WAVE   = 4'd2;
  localparam logic [SEG_W-1:0] SEG_BLEND0 = 4'd3;
  localparam logic [SEG_W-1:0] SEG_END    = 4'd8;

  typedef enum logic [3:0] {
    OP_MUL, OP_DIV, OP_ADD, OP_SUB, OP_MIN, OP_MAX,
    OP_PSRN, OP_PSLP, OP_OUT, OP_END
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
  } uop_t;

  function automatic uop_t mk(input op_t op, input logic [ADDR_W-1:0] d,
                              input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] b);
    uop_t u;
    u.op  = op;
    u.dst = d;
    u.a   = a;
    u.b   = b;
    return u;
  endfunction

  function automatic logic [ADDR_W-1:0] ad(input logic [ADDR_W-1:0] base, input int n);
    return base + ADDR_W'(n);
  endfunction

  // Number of micro-operations in each segment.
  function automatic logic [STEP_W-1:0] seg_len(input logic [SEG_W-1:0] seg);
    logic [STEP_W-1:0] n;
    if (seg == SEG_OWN || seg == SEG_NBR) n = 5'd22;
    else if (seg == SEG_WAVE) n = 5'd9;
    else if (seg >= SEG_BLEND0 && seg < SEG_END) n = 5'd11;
    else n = 5'd1;
    return n;
  endfunction

  // Micro-program: side terms for each side, wave speeds, then one blend per flux.
  function automatic uop_t ucode(input logic [SEG_W-1:0] seg, input logic [STEP_W-1:0] step);
    logic [ADDR_W-1:0] sb, un, mm, fb, qb, fo, fn, qo, qn;
    logic [2:0]        k;
    uop_t              u;
    sb = (seg == SEG_OWN) ? A_O0   : A_N0;
    un = (seg == SEG_OWN) ? A_UN_O : A_UN_N;
    mm = (seg == SEG_OWN) ? A_MO   : A_MN;
    fb = (seg == SEG_OWN) ? A_FO1  : A_FN1;
    qb = (seg == SEG_OWN) ? A_QO1  : A_QN1;
    k  = 3'(seg - SEG_BLEND0);
    fo = (k == 3'd0) ? A_MO : ad(A_FO1, int'(k) - 1);
    fn = (k == 3'd0) ? A_MN : ad(A_FN1, int'(k) - 1);
    qo = (k == 3'd0) ? A_O0 : ad(A_QO1, int'(k) - 1);
    qn = (k == 3'd0) ? A_N0 : ad(A_QN1, int'(k) - 1);
    u  = mk(OP_END, A_O0, A_O0, A_O0);
    if (seg == SEG_OWN || seg == SEG_NBR) begin
      case (step)
        5'd0:  u = mk(OP_MUL, un, ad(sb, 1), A_NX);
        5'd1:  u = mk(OP_MUL, A_T, ad(sb, 2), A_NY);
        5'd2:  u = mk(OP_ADD, un, un, A_T);
        5'd3:  u = mk(OP_MUL, A_T, ad(sb, 3), A_NZ);
        5'd4:  u = mk(OP_ADD, un, un, A_T);
        5'd5:  u = mk(OP_DIV, A_E, ad(sb, 5), sb);
        5'd6:  u = mk(OP_SUB, A_E, ad(sb, 4), A_E);
        5'd7:  u = mk(OP_MUL, mm, sb, un);
        5'd8:  u = mk(OP_MUL, fb, ad(sb, 1), mm);
        5'd9:  u = mk(OP_MUL, A_T, ad(sb, 5), A_NX);
        5'd10: u = mk(OP_ADD, fb, fb, A_T);
        5'd11: u = mk(OP_MUL, ad(fb, 1), ad(sb, 2), mm);
        5'd12: u = mk(OP_MUL, A_T, ad(sb, 5), A_NY);
        5'd13: u = mk(OP_ADD, ad(fb, 1), ad(fb, 1), A_T);
        5'd14: u = mk(OP_MUL, ad(fb, 2), ad(sb, 3), mm);
        5'd15: u = mk(OP_MUL, A_T, ad(sb, 5), A_NZ);
        5'd16: u = mk(OP_ADD, ad(fb, 2), ad(fb, 2), A_T);
        5'd17: u = mk(OP_MUL, ad(fb, 3), ad(sb, 4), mm);
        5'd18: u = mk(OP_MUL, qb, sb, ad(sb, 1));
        5'd19: u = mk(OP_MUL, ad(qb, 1), sb, ad(sb, 2));
        5'd20: u = mk(OP_MUL, ad(qb, 2), sb, ad(sb, 3));
        5'd21: u = mk(OP_MUL, ad(qb, 3), sb, A_E);
        default: u = mk(OP_END, A_O0, A_O0, A_O0);
      endcase
    end else if (seg == SEG_WAVE) begin
      case (step)
        5'd0: u = mk(OP_SUB, A_T1, A_UN_O, ad(A_O0, 6));
        5'd1: u = mk(OP_SUB, A_T2, A_UN_N, ad(A_N0, 6));
        5'd2: u = mk(OP_MIN, A_SL, A_T1, A_T2);
        5'd3: u = mk(OP_ADD, A_T1, A_UN_N, ad(A_N0, 6));
        5'd4: u = mk(OP_ADD, A_T2, A_UN_O, ad(A_O0, 6));
        5'd5: u = mk(OP_MAX, A_SR, A_T1, A_T2);
        5'd6: u = mk(OP_SUB, A_T, A_SR, A_SL);
        5'd7: u = mk(OP_DIV, A_R, A_ONE, A_T);
        5'd8: u = mk(OP_MUL, A_SLSR, A_SL, A_SR);
        default: u = mk(OP_END, A_O0, A_O0, A_O0);
      endcase
    end else if (seg >= SEG_BLEND0 && seg < SEG_END) begin
      case (step)
        5'd0:  u = mk(OP_MUL, A_X, A_SR, fo);
        5'd1:  u = mk(OP_MUL, A_Y, A_SL, fn);
        5'd2:  u = mk(OP_SUB, A_X, A_X, A_Y);
        5'd3:  u = mk(OP_SUB, A_Y, qn, qo);
        5'd4:  u = mk(OP_MUL, A_Y, A_SLSR, A_Y);
        5'd5:  u = mk(OP_ADD, A_X, A_X, A_Y);
        5'd6:  u = mk(OP_MUL, A_X, A_X, A_R);
        5'd7:  u = mk(OP_PSRN, A_X, fn, A_X);
        5'd8:  u = mk(OP_PSLP, A_X, fo, A_X);
        5'd9:  u = mk(OP_MUL, A_X, A_AREA, A_X);
        5'd10: u = mk(OP_OUT, ADDR_W'(k), A_X, A_X);
        default: u = mk(OP_END, A_O0, A_O0, A_O0);
      endcase
    end
    return u;
  endfunction

endpackage

>>> rtl/core/hll_euler_face_flux_core.sv
// ----------------------------------------------------------------------------
// hll_euler_face_flux_core
// HLL Riemann flux of the Euler equations across one face, fixed point.
// ----------------------------------------------------------------------------
// A face is two beats: an owner-side state, which is held, then a
// neighbour-side state with the face normal and area, which returns one beat
// of area-weighted mass, momentum and energy flux. All arithmetic runs on one
// shared unit under a micro-sequencer with a 64-entry register file. An owner
// beat is captured and its seven words written to the register file; a
// neighbour beat without a held owner is dropped. A completing neighbour beat
// loads 12 register-file words, then runs 56 multiplies, 3 divides and 49
// other operations on the default Q24.24 word or the one set by the
// parameters; the next beat can be taken in the cycle its result is raised.
// The multiply works one 16-bit digit per cycle and the restoring divide one
// quotient bit per cycle; a divide by zero skips the iteration and writes a
// saturated result. Input is not taken until the face is finished; a finished
// result waits in its output register, and the next face stalls in its
// finishing state for as long as the previous result has not been taken.
module hll_euler_face_flux_core #(
  parameter int WORD_BITS = hef_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = hef_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic        [hef_pkg::UW-1:0] in_density,
  input  logic signed [hef_pkg::SW-1:0] in_vel_x,
  input  logic signed [hef_pkg::SW-1:0] in_vel_y,
  input  logic signed [hef_pkg::SW-1:0] in_vel_z,
  input  logic signed [hef_pkg::SW-1:0] in_enthalpy,
  input  logic        [hef_pkg::UW-1:0] in_pressure,
  input  logic        [hef_pkg::UW-1:0] in_sound_speed,
  input  logic signed [hef_pkg::NW-1:0] in_normal_x,
  input  logic signed [hef_pkg::NW-1:0] in_normal_y,
  input  logic signed [hef_pkg::NW-1:0] in_normal_z,
  input  logic        [hef_pkg::UW-1:0] in_face_area,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [hef_pkg::OW-1:0] out_mass_flux,
  output logic signed [hef_pkg::OW-1:0] out_mom_flux_x,
  output logic signed [hef_pkg::OW-1:0] out_mom_flux_y,
  output logic signed [hef_pkg::OW-1:0] out_mom_flux_z,
  output logic signed [hef_pkg::OW-1:0] out_energy_flux
);
  import hef_pkg::*;

  localparam int W     = WORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int EW    = ((W > SW) ? W : SW) + 1;
  localparam int NCH   = (W + 15) / 16;
  localparam int MB_W  = NCH * 16;
  localparam int QW    = W + F;
  localparam int CNT_W = $clog2(QW);
  localparam int DEPTH = 1 << ADDR_W;

  localparam logic [W-1:0] WMAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN_W = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [EW-1:0] WMAX_E = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [EW-1:0] WMIN_E = ~WMAX_E;
  localparam logic signed [EW-1:0] OMAX_E = {{(EW-OW+1){1'b0}}, {(OW-1){1'b1}}};
  localparam logic signed [EW-1:0] OMIN_E = ~OMAX_E;
  localparam logic [2*W-1:0] LIM_P = (2*W)'(WMAX_W);
  localparam logic [2*W-1:0] LIM_N = LIM_P + (2*W)'(1);
  localparam logic [W-1:0] ONE_W = (F + 2 <= W) ? ({{(W-1){1'b0}}, 1'b1} << F) : WMAX_W;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_LOAD = 8'b0000_0010,
    ST_RD   = 8'b0000_0100,
    ST_EX   = 8'b0000_1000,
    ST_MUL  = 8'b0001_0000,
    ST_DIV  = 8'b0010_0000,
    ST_FIN  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

  // Saturate a widened value to the working word.
  function automatic logic [W-1:0] clamp_in(input logic signed [EW-1:0] v);
    logic [W-1:0] r;
    if (v > WMAX_E) r = WMAX_W;
    else if (v < WMIN_E) r = WMIN_W;
    else r = v[W-1:0];
    return r;
  endfunction

  // Saturate a working word to the output field.
  function automatic logic [OW-1:0] clamp_out(input logic [W-1:0] x);
    logic signed [EW-1:0] v;
    logic [OW-1:0]        r;
    v = EW'($signed(x));
    if (v > OMAX_E) r = OMAX_E[OW-1:0];
    else if (v < OMIN_E) r = OMIN_E[OW-1:0];
    else r = v[OW-1:0];
    return r;
  endfunction

  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    return x[W-1] ? -x : x;
  endfunction

  // Signed result from a magnitude, saturated.
  function automatic logic [W-1:0] sat_mag(input logic [2*W-1:0] q, input logic neg);
    logic [W-1:0] r;
    if (neg) r = (q > LIM_N) ? WMIN_W : -q[W-1:0];
    else     r = (q > LIM_P) ? WMAX_W : q[W-1:0];
    return r;
  endfunction

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic sub);
    logic [W:0]   s;
    logic [W-1:0] r;
    s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
    if (s[W] != s[W-1]) r = s[W] ? WMIN_W : WMAX_W;
    else r = s[W-1:0];
    return r;
  endfunction

  state_t                    state_r;
  logic                      owner_present_r;
  logic                      ld_owner_r;
  logic [3:0]                ld_cnt_r;
  logic [SEG_W-1:0]          seg_r;
  logic [STEP_W-1:0]         step_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      out_valid_r;
  logic [W-1:0]              cap_r [11];
  logic [W-1:0]              regf_r [DEPTH];
  logic [W-1:0]              opa_r, opb_r;
  logic [W-1:0]              ma_r;
  logic [MB_W-1:0]           mb_r;
  logic [2*W-1:0]            acc_r;
  logic [QW-1:0]             quo_r;
  logic [W-1:0]              rem_r, db_r;
  logic                      neg_r;
  logic                      sl_neg_r, sr_neg_r;
  logic [OW-1:0]             res_r [5];
  logic [OW-1:0]             out_r [5];

  uop_t                      uop;
  logic                      we;
  logic [ADDR_W-1:0]         waddr;
  logic [W-1:0]              wdata;
  logic                      advance;
  logic                      ld_last;
  logic [W+15:0]             prod;
  logic [2*W-1:0]            acc_nxt;
  logic [W:0]                rem2;
  logic                      ge;
  logic [W-1:0]              rem_nxt;
  logic [QW-1:0]             quo_nxt;
  logic [2*W-1:0]            fin_q;

  assign uop       = ucode(seg_r, step_r);
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign ld_last   = ld_owner_r ? (ld_cnt_r == 4'd6) : (ld_cnt_r == 4'd11);

  assign out_mass_flux   = out_r[0];
  assign out_mom_flux_x  = out_r[1];
  assign out_mom_flux_y  = out_r[2];
  assign out_mom_flux_z  = out_r[3];
  assign out_energy_flux = out_r[4];

  // Shared unit: one 16-bit digit of a multiply, one bit of a divide.
  assign prod    = ma_r * mb_r[MB_W-1 -: 16];
  assign acc_nxt = (acc_r << 16) + (2*W)'(prod);
  assign rem2    = {rem_r, quo_r[QW-1]};
  assign ge      = rem2 >= {1'b0, db_r};
  assign rem_nxt = ge ? W'(rem2 - {1'b0, db_r}) : rem2[W-1:0];
  assign quo_nxt = {quo_r[QW-2:0], ge};
  assign fin_q   = (uop.op == OP_DIV) ? (2*W)'(quo_r) : (acc_r >> F);

  // Register-file write port and sequencer advance.
  always_comb begin
    we      = 1'b0;
    waddr   = uop.dst;
    wdata   = opa_r;
    advance = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        we = 1'b1;
        if (ld_owner_r) begin
          waddr = A_O0 + ADDR_W'(ld_cnt_r);
          wdata = cap_r[ld_cnt_r];
        end else if (ld_cnt_r == 4'd11) begin
          waddr = A_ONE;
          wdata = ONE_W;
        end else begin
          waddr = A_N0 + ADDR_W'(ld_cnt_r);
          wdata = cap_r[ld_cnt_r];
        end
      end
      ST_EX: begin
        case (uop.op)
          OP_ADD:  begin we = 1'b1; wdata = sat_add(opa_r, opb_r, 1'b0); end
          OP_SUB:  begin we = 1'b1; wdata = sat_add(opa_r, opb_r, 1'b1); end
          OP_MIN:  begin we = 1'b1; wdata = ($signed(opa_r) < $signed(opb_r)) ? opa_r : opb_r; end
          OP_MAX:  begin we = 1'b1; wdata = ($signed(opa_r) > $signed(opb_r)) ? opa_r : opb_r; end
          OP_PSRN: begin we = 1'b1; wdata = sr_neg_r ? opa_r : opb_r; end
          OP_PSLP: begin we = 1'b1; wdata = !sl_neg_r ? opa_r : opb_r; end
          OP_DIV: begin
            if (opb_r == '0) begin
              we    = 1'b1;
              wdata = opa_r[W-1] ? WMIN_W : WMAX_W;
            end
          end
          default: we = 1'b0;
        endcase
        advance = we || (uop.op == OP_OUT);
      end
      ST_FIN: begin
        we      = 1'b1;
        wdata   = sat_mag(fin_q, neg_r);
        advance = 1'b1;
      end
      default: we = 1'b0;
    endcase
  end

  // Register file: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      regf_r[waddr] <= wdata;
    end
    if (state_r == ST_RD) begin
      opa_r <= regf_r[uop.a];
      opb_r <= regf_r[uop.b];
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      owner_present_r <= 1'b0;
      ld_owner_r      <= 1'b0;
      ld_cnt_r        <= '0;
      seg_r           <= '0;
      step_r          <= '0;
      cnt_r           <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        if (step_r == seg_len(seg_r) - 5'd1) begin
          step_r <= '0;
          seg_r  <= seg_r + 4'd1;
        end else begin
          step_r <= step_r + 5'd1;
        end
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            ld_cnt_r   <= '0;
            ld_owner_r <= !in_kind;
            if (!in_kind) begin
              owner_present_r <= 1'b1;
              state_r         <= ST_LOAD;
            end else if (owner_present_r) begin
              owner_present_r <= 1'b0;
              state_r         <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          ld_cnt_r <= ld_cnt_r + 4'd1;
          if (ld_last) begin
            if (ld_owner_r) begin
              state_r <= ST_IDLE;
            end else begin
              seg_r   <= SEG_OWN;
              step_r  <= '0;
              state_r <= ST_RD;
            end
          end
        end
        ST_RD: state_r <= ST_EX;
        ST_EX: begin
          cnt_r <= '0;
          if (advance) begin
            state_r <= ST_RD;
          end else if (uop.op == OP_MUL) begin
            state_r <= ST_MUL;
          end else if (uop.op == OP_DIV) begin
            state_r <= ST_DIV;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_MUL: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(NCH - 1)) begin
            state_r <= ST_FIN;
          end
        end
        ST_DIV: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(QW - 1)) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: state_r <= ST_RD;
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    // Capture the beat, saturated to the working word.
    if (state_r == ST_IDLE && in_valid) begin
      cap_r[0]  <= clamp_in(EW'(in_density));
      cap_r[1]  <= clamp_in(EW'(in_vel_x));
      cap_r[2]  <= clamp_in(EW'(in_vel_y));
      cap_r[3]  <= clamp_in(EW'(in_vel_z));
      cap_r[4]  <= clamp_in(EW'(in_enthalpy));
      cap_r[5]  <= clamp_in(EW'(in_pressure));
      cap_r[6]  <= clamp_in(EW'(in_sound_speed));
      cap_r[7]  <= clamp_in(EW'(in_normal_x));
      cap_r[8]  <= clamp_in(EW'(in_normal_y));
      cap_r[9]  <= clamp_in(EW'(in_normal_z));
      cap_r[10] <= clamp_in(EW'(in_face_area));
    end
    // Operand set-up for multiply and divide.
    if (state_r == ST_EX && uop.op == OP_MUL) begin
      ma_r  <= mag(opa_r);
      mb_r  <= MB_W'(mag(opb_r));
      acc_r <= '0;
      neg_r <= opa_r[W-1] ^ opb_r[W-1];
    end
    if (state_r == ST_EX && uop.op == OP_DIV) begin
      db_r  <= mag(opb_r);
      rem_r <= '0;
      quo_r <= {mag(opa_r), {F{1'b0}}};
      neg_r <= opa_r[W-1] ^ opb_r[W-1];
    end
    if (state_r == ST_MUL) begin
      acc_r <= acc_nxt;
      mb_r  <= mb_r << 16;
    end
    if (state_r == ST_DIV) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    // Wave-speed signs steer the blend.
    if (we && waddr == A_SL) begin
      sl_neg_r <= wdata[W-1];
    end
    if (we && waddr == A_SR) begin
      sr_neg_r <= wdata[W-1];
    end
    // Finished fluxes are staged, then moved to the output register.
    if (state_r == ST_EX && uop.op == OP_OUT) begin
      res_r[uop.dst[2:0]] <= clamp_out(opa_r);
    end
    if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
      out_r <= res_r;
    end
  end

  // A completing neighbour beat consumes the held owner state.
  a_owner_used: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind && owner_present_r) |=> !owner_present_r)
    else $error("owner state not released after a completed face");

  // An owner beat always leaves a held owner state.
  a_owner_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_kind) |=> owner_present_r)
    else $error("owner beat not held");

  // The divider never iterates on a zero divisor.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (db_r != '0))
    else $error("divide iterating on zero divisor");

  // A result is raised only from the finishing state.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the finishing state");

endmodule
